// ----- sv/gww_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

  // byte codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // configuration register
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd63;
  localparam int WIDTH_MAX = 63;

  // counters and storage
  localparam int LINE_CNT_W  = 7;
  localparam int WORD_DEPTH_DEF = 64;

  // emitter sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SPACE,
    S_WORD,
    S_NL
  } state_t;

endpackage

`default_nettype wire

// ----- sv/greedy_word_wrap.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                ports
// --------  ---  -----------------------  ------------------------------
// input     in   in_valid / in_stall      in_char, in_end_of_text
// result    out  out_valid / out_stall    out_char, out_last_of_run
// config    in   cfg_valid / cfg_ready    cfg_line_width
//
// An item is taken in the idle state, then its bytes are emitted in order; a word flush first
// reads the word memory, later word bytes stream at one per cycle from its registered read port
// while the output is not stalled. An item with no bytes leaves the sequencer idle.
// The next item is taken the cycle after its last byte enters the output register.
// Reset (rst_n low, synchronous) clears counters, sequencer and line_width to 63.
// A stalled output holds the output register and pauses the sequencer.

module greedy_word_wrap #(
  parameter int WORD_DEPTH = gww_pkg::WORD_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [7:0]                in_char,
  input  wire                       in_end_of_text,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [7:0]                out_char,
  output logic                      out_last_of_run,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [gww_pkg::CFG_W-1:0] cfg_line_width
);

  localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int LW = gww_pkg::LINE_CNT_W;
  localparam int SW = ((CW > LW) ? CW : LW) + 1;
  localparam int WCAP_I = (WORD_DEPTH - 1 > gww_pkg::WIDTH_MAX) ?
                          gww_pkg::WIDTH_MAX : WORD_DEPTH - 1;
  localparam logic [SW-1:0] WCAP = SW'(WCAP_I);

  gww_pkg::state_t state_r, state_nxt;

  logic [gww_pkg::CFG_W-1:0] cfg_width_r;
  logic [CW-1:0]  word_cnt_r, word_cnt_nxt;
  logic [LW-1:0]  line_cnt_r, line_cnt_nxt;
  logic [CW-1:0]  wlen_r, rd_idx_r;
  logic [1:0]     nl_r;
  logic           pend_r;
  logic [7:0]     mem_q_r;
  logic [7:0]     word_mem [WORD_DEPTH];

  logic           out_valid_r, out_last_r;
  logic [7:0]     out_char_r;

  logic           in_acc, slot_free, more_rd;
  logic [SW-1:0]  weff, wz;
  logic           plan_sp, wr_en;
  logic [CW-1:0]  plan_wlen, wc1;
  logic [1:0]     plan_nl;
  logic [SW-1:0]  sum_sp, sum_ch;
  logic           load, load_last, rd_en;
  logic [7:0]     load_char;

  assign in_stall  = (state_r != gww_pkg::S_IDLE);
  assign cfg_ready = (state_r == gww_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign more_rd   = (rd_idx_r < wlen_r);

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

  // effective line width: zero acts as one, capped by the word store
  always_comb begin
    wz   = (cfg_width_r == '0) ? SW'(1) : SW'(cfg_width_r);
    weff = (wz > WCAP) ? WCAP : wz;
  end

  // plan for the item on the input: separator, word bytes, newlines
  always_comb begin
    plan_sp      = 1'b0;
    plan_wlen    = '0;
    plan_nl      = 2'd0;
    word_cnt_nxt = word_cnt_r;
    line_cnt_nxt = line_cnt_r;
    wr_en        = 1'b0;
    wc1          = word_cnt_r;
    sum_sp       = SW'(line_cnt_r) + SW'(line_cnt_r != '0) + SW'(word_cnt_r);
    sum_ch       = '0;
    if (in_end_of_text) begin
      plan_wlen    = word_cnt_r;
      plan_nl      = 2'd1;
      word_cnt_nxt = '0;
      line_cnt_nxt = '0;
    end else if (in_char == gww_pkg::CH_SPACE) begin
      plan_sp      = (line_cnt_r != '0);
      plan_wlen    = word_cnt_r;
      word_cnt_nxt = '0;
      if (sum_sp >= weff) begin
        plan_nl      = 2'd1;
        line_cnt_nxt = '0;
      end else begin
        line_cnt_nxt = sum_sp[LW-1:0];
      end
    end else if (in_char == gww_pkg::CH_CR) begin
      plan_sp      = (line_cnt_r != '0);
      plan_wlen    = word_cnt_r;
      plan_nl      = 2'd2;
      word_cnt_nxt = '0;
      line_cnt_nxt = '0;
    end else begin
      if (word_cnt_r < CW'(WORD_DEPTH)) begin
        wr_en = 1'b1;
        wc1   = word_cnt_r + CW'(1);
      end
      word_cnt_nxt = wc1;
      sum_ch       = SW'(line_cnt_r) + SW'(wc1);
      if (sum_ch >= weff) begin
        plan_nl      = 2'd1;
        line_cnt_nxt = '0;
        if (line_cnt_r == '0) begin
          plan_wlen    = wc1;
          word_cnt_nxt = '0;
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gww_pkg::S_IDLE: begin
        if (in_acc) begin
          if (plan_sp) begin
            state_nxt = gww_pkg::S_SPACE;
          end else if (plan_wlen != '0) begin
            state_nxt = gww_pkg::S_WORD;
          end else if (plan_nl != 2'd0) begin
            state_nxt = gww_pkg::S_NL;
          end
        end
      end
      gww_pkg::S_SPACE: begin
        if (slot_free) begin
          if (wlen_r != '0) begin
            state_nxt = gww_pkg::S_WORD;
          end else if (nl_r != 2'd0) begin
            state_nxt = gww_pkg::S_NL;
          end else begin
            state_nxt = gww_pkg::S_IDLE;
          end
        end
      end
      gww_pkg::S_WORD: begin
        if (pend_r && slot_free && !more_rd) begin
          state_nxt = (nl_r != 2'd0) ? gww_pkg::S_NL : gww_pkg::S_IDLE;
        end
      end
      gww_pkg::S_NL: begin
        if (slot_free && nl_r == 2'd1) begin
          state_nxt = gww_pkg::S_IDLE;
        end
      end
      default: state_nxt = gww_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: output register load and word memory reads
  always_comb begin
    load      = 1'b0;
    load_char = gww_pkg::CH_NL;
    load_last = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      gww_pkg::S_SPACE: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = gww_pkg::CH_SPACE;
          load_last = (wlen_r == '0) && (nl_r == 2'd0);
        end
      end
      gww_pkg::S_WORD: begin
        if (!pend_r) begin
          rd_en = more_rd;
        end else if (slot_free) begin
          load      = 1'b1;
          load_char = mem_q_r;
          load_last = !more_rd && (nl_r == 2'd0);
          rd_en     = more_rd;
        end
      end
      gww_pkg::S_NL: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = gww_pkg::CH_NL;
          load_last = (nl_r == 2'd1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // word store: write on accepted text byte, registered read
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      word_mem[word_cnt_r[AW-1:0]] <= in_char;
    end
    if (rd_en) begin
      mem_q_r <= word_mem[rd_idx_r[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gww_pkg::S_IDLE;
      cfg_width_r <= gww_pkg::WIDTH_RESET;
      word_cnt_r  <= '0;
      line_cnt_r  <= '0;
      wlen_r      <= '0;
      nl_r        <= 2'd0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_width_r <= cfg_line_width;
      end
      if (in_acc) begin
        word_cnt_r <= word_cnt_nxt;
        line_cnt_r <= line_cnt_nxt;
        wlen_r     <= plan_wlen;
        nl_r       <= plan_nl;
        rd_idx_r   <= '0;
      end else begin
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
        if (load && state_r == gww_pkg::S_NL) begin
          nl_r <= nl_r - 2'd1;
        end
      end
      if (rd_en) begin
        pend_r <= 1'b1;
      end else if (load && state_r == gww_pkg::S_WORD) begin
        pend_r <= 1'b0;
      end
      // output register: refill on load, empty after a transfer
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= load_char;
      out_last_r <= load_last;
    end
  end

  // checks
  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_cnt_r <= CW'(WORD_DEPTH))
    else $error("word count beyond store depth");

  a_pend_word: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == gww_pkg::S_WORD)
    else $error("read data pending outside word flush");

  a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gww_pkg::S_WORD |-> rd_idx_r <= wlen_r)
    else $error("word read index past word length");

  a_nl_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gww_pkg::S_NL |-> nl_r != 2'd0)
    else $error("newline phase with no newline left");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = gww_pkg::WORD_DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  // predicts the reflowed text and checks each emitted byte against it
  class reflow_checker_t;
    bit [gww_pkg::CFG_W-1:0] line_width;
    logic [7:0]     word_bytes [DEPTH];
    int             word_len;
    int             line_fill;
    text_byte_t     expected_text[$];
    text_byte_t     run_bytes[$];
    int             errors;

    function new();
      line_width = gww_pkg::WIDTH_RESET;
      word_len   = 0;
      line_fill  = 0;
      errors     = 0;
    endfunction

    function void emit(logic [7:0] ch);
      text_byte_t b;
      b.ch   = ch;
      b.last = 1'b0;
      run_bytes.push_back(b);
    endfunction

    function void emit_word();
      for (int i = 0; i < word_len && i < DEPTH; i++) emit(word_bytes[i]);
    endfunction

    // one accepted input transfer: work out the bytes it releases
    function void take_byte(logic [7:0] ch, logic eot);
      int w;
      w = int'(line_width);
      if (w == 0) w = 1;
      if (w > DEPTH - 1) w = DEPTH - 1;
      run_bytes.delete();
      if (eot) begin
        emit_word();
        emit(gww_pkg::CH_NL);
        word_len  = 0;
        line_fill = 0;
      end else if (ch == gww_pkg::CH_SPACE) begin
        // join the word to the line, break when the line is full
        if (line_fill != 0) begin
          emit(gww_pkg::CH_SPACE);
          line_fill++;
        end
        emit_word();
        line_fill += word_len;
        word_len = 0;
        if (line_fill >= w) begin
          emit(gww_pkg::CH_NL);
          line_fill = 0;
        end
      end else if (ch == gww_pkg::CH_CR) begin
        // paragraph end
        if (line_fill != 0) emit(gww_pkg::CH_SPACE);
        emit_word();
        emit(gww_pkg::CH_NL);
        emit(gww_pkg::CH_NL);
        word_len  = 0;
        line_fill = 0;
      end else begin
        // buffer the byte, then break the line or flush an oversized word
        if (word_len < DEPTH) begin
          word_bytes[word_len] = ch;
          word_len++;
        end
        if (line_fill + word_len >= w) begin
          if (line_fill == 0) begin
            emit_word();
            emit(gww_pkg::CH_NL);
            word_len = 0;
          end else begin
            emit(gww_pkg::CH_NL);
          end
          line_fill = 0;
        end
      end
      line_fill &= 'h7f;
      word_len  &= 'h7f;
      if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
      foreach (run_bytes[i]) expected_text.push_back(run_bytes[i]);
    endfunction

    // one accepted result transfer
    function void check_emitted(logic [7:0] ch, logic last);
      text_byte_t want;
      if (expected_text.size() == 0) begin
        $error("out_char expected none actual %h", ch);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (ch !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, ch);
          errors++;
        end
        if (last !== want.last) begin
          $error("out_last_of_run expected %b actual %b", want.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic [7:0]       in_char        = '0;
  logic             in_end_of_text = 1'b0;
  logic             out_stall      = 1'b0;
  logic             cfg_valid      = 1'b0;
  logic [gww_pkg::CFG_W-1:0] cfg_line_width = '0;
  wire              in_stall;
  wire              out_valid;
  wire  [7:0]       out_char;
  wire              out_last_of_run;
  wire              cfg_ready;

  reflow_checker_t sb;
  int            items_sent   = 0;
  int            burst_left   = 0;
  bit            steady       = 1'b0;
  int            cur_width    = 63;
  int            stall_mode   = 0;
  int            stall_left   = 0;
  int            quiet_cycles = 0;

  greedy_word_wrap #(
    .WORD_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last_of_run(out_last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_width (cfg_line_width)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern, switching between styles now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 16) < 6);
    endcase
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_emitted(out_char, out_last_of_run);
      if (in_valid && !in_stall) sb.take_byte(in_char, in_end_of_text);
      if (cfg_valid && cfg_ready) sb.line_width = cfg_line_width;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[greedy_word_wrap] ERROR");
      $finish;
    end
  end

  // one input transfer, then the sender's burst and gap pacing
  task automatic put_item(input logic [7:0] ch, input logic eot);
    int gap;
    in_valid       <= 1'b1;
    in_char        <= ch;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endtask

  // hold the sender until all expected bytes are out and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor record the last accepted input first
    @(posedge clk);
    while (sb.expected_text.size() != 0 || out_valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input int v);
    cfg_valid      <= 1'b1;
    cfg_line_width <= v[gww_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_width = v;
  endtask

  // random text: mostly words and separators, some raw noise
  task automatic run_text(input int n);
    int         target;
    int         len;
    int         sep;
    logic [7:0] c;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        put_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        case ($urandom_range(0, 39))
          0:             len = $urandom_range(40, 70);
          1, 2, 3, 4, 5: len = $urandom_range(1, cur_width + 2);
          default:       len = $urandom_range(1, 7);
        endcase
        repeat (len) begin
          do c = 8'($urandom_range(0, 255));
          while (c == gww_pkg::CH_SPACE || c == gww_pkg::CH_CR);
          put_item(c, 1'b0);
        end
        sep = $urandom_range(0, 19);
        if (sep < 15) put_item(gww_pkg::CH_SPACE, 1'b0);
        if (sep == 13 || sep == 14) put_item(gww_pkg::CH_SPACE, 1'b0);
        if (sep == 15 || sep == 16) put_item(gww_pkg::CH_CR, 1'b0);
        if (sep == 17) put_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    int w;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: byte extremes, repeated spaces, return on a non-empty line
    put_text("a");
    put_item(8'h00, 1'b0);
    put_item(8'hff, 1'b0);
    put_item(gww_pkg::CH_SPACE, 1'b0);
    put_item(gww_pkg::CH_SPACE, 1'b0);
    put_item(gww_pkg::CH_CR, 1'b0);
    put_text("x");
    put_item(gww_pkg::CH_CR, 1'b1);

    // zero width behaves as one
    drain();
    set_width(0);
    put_text("q ");
    put_item(gww_pkg::CH_SPACE, 1'b1);

    // narrow lines: line break with word kept, word filling a line
    drain();
    set_width(4);
    put_text("ab cdef ");
    put_item(gww_pkg::CH_SPACE, 1'b0);
    put_item(gww_pkg::CH_CR, 1'b0);
    put_text("hi ");

    // width lowered below the current line fill
    drain();
    set_width(1);
    put_text("j");
    put_item(8'h00, 1'b1);

    // random phases over several widths
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       w = 63;
        2:       w = 1;
        3:       w = $urandom_range(2, 8);
        4:       w = 0;
        default: w = $urandom_range(0, 63);
      endcase
      drain();
      set_width(w);
      run_text(40);
      if (p == 3) begin
        drain();
        run_text(20);
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_text.size() == 0) begin
      $display("[greedy_word_wrap] OK");
    end else begin
      $display("[greedy_word_wrap] ERROR");
    end
    $finish;
  end

endmodule
